[src/ypb_pkg.sv]
`timescale 1ns / 1ps

package ypb_pkg;

    localparam int SINE_LAT = 24;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // pi in Q30 split as 45 * PI_DIV45_Q + PI_DIV45_R
    localparam logic [26:0] PI_DIV45_Q = 27'd74961320;
    localparam int          PI_DIV45_R = 26;

    localparam int HORNER_STEPS = 8;

    function automatic int horner_div(input int step);
        int k;
        k = HORNER_STEPS - step;
        return (2 * k) * (2 * k + 1);
    endfunction

endpackage

[src/ypb_sine.sv]
`timescale 1ns / 1ps

module ypb_sine #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int EW              = 19
) (
    input  logic                              i_clk,
    input  logic [ypb_pkg::SINE_LAT-1:0]      i_en,
    input  logic signed [EW-1:0]              i_ang,
    output logic signed [31:0]                o_sin
);

    localparam int A       = ANGLE_FRAC_BITS;
    localparam int WN      = EW - A;
    localparam int OFF     = 180 * ((1 << (EW - A - 2)) / 180 + 1);
    localparam int QUARTER = 90 << A;
    localparam int TW      = A + 7;
    localparam int S45     = WN + 6;
    localparam logic [WN:0] M45 = (WN + 1)'(((64'd1 << S45) + 64'd44) / 64'd45);
    localparam int N26     = TW + 5;
    localparam int S26     = N26 + 6;
    localparam logic [N26:0] M26 = (N26 + 1)'(((64'd1 << S26) + 64'd44) / 64'd45);

    logic [WN-1:0]   r_wn;
    logic [A:0]      r_lo;
    logic [WN-1:0]   r_qd;
    logic [WN-1:0]   r_wn1;
    logic [A:0]      r_lo1;
    logic [TW-1:0]   r_t;
    logic [TW+26:0]  r_tq;
    logic [TW-1:0]   r_d26;
    logic            r_neg [2:22];
    logic [30:0]     r_x   [4:21];
    logic [31:0]     r_x2  [5:19];
    logic [31:0]     r_a   [0:ypb_pkg::HORNER_STEPS-1];
    logic [30:0]     r_p   [0:ypb_pkg::HORNER_STEPS-1];
    logic [31:0]     r_y;
    logic signed [31:0] r_sin;

    logic signed [EW-1:0] ang_sh;
    logic [2*WN:0]        prod45;
    logic [WN-1:0]        rem_full;
    logic [TW-1:0]        f_ang;
    logic [TW+4:0]        t26;
    logic [2*N26+1:0]     prod26;
    logic [TW+26:0]       u_sum;
    logic [61:0]          xx;
    logic [61:0]          yy;
    logic [30:0]          m_clamp;

    assign ang_sh   = i_ang >>> (A + 1);
    assign prod45   = (2 * WN + 1)'(r_wn) * (2 * WN + 1)'(M45);
    assign rem_full = r_wn1 - WN'(r_qd * WN'(45));
    assign f_ang    = {rem_full[5:0], r_lo1};
    assign t26      = (TW + 5)'(r_t) * (TW + 5)'(ypb_pkg::PI_DIV45_R);
    assign prod26   = (2 * N26 + 2)'(t26) * (2 * N26 + 2)'(M26);
    assign u_sum    = r_tq + (TW + 27)'(r_d26);
    assign xx       = 62'(r_x[4]) * 62'(r_x[4]);
    assign yy       = 62'(r_x[21]) * 62'(r_p[ypb_pkg::HORNER_STEPS-1]);
    assign m_clamp  = (r_y > 32'(ypb_pkg::ONE_Q30)) ? ypb_pkg::ONE_Q30 : r_y[30:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_wn <= ang_sh[WN-1:0] + WN'(OFF);
            r_lo <= i_ang[A:0];
        end
        if (i_en[1]) begin
            r_qd  <= WN'(prod45 >> S45);
            r_wn1 <= r_wn;
            r_lo1 <= r_lo;
        end
        if (i_en[2]) begin
            r_t      <= r_qd[0] ? TW'(QUARTER) - f_ang : f_ang;
            r_neg[2] <= r_qd[1];
        end
        if (i_en[3]) begin
            r_tq  <= (TW + 27)'(r_t) * (TW + 27)'(ypb_pkg::PI_DIV45_Q);
            r_d26 <= TW'(prod26 >> S26);
        end
        if (i_en[4]) begin
            r_x[4] <= u_sum[A+32:A+2];
        end
        if (i_en[5]) begin
            r_x2[5] <= xx[61:30];
        end
        for (int k = 3; k <= 22; k++) begin
            if (i_en[k]) r_neg[k] <= r_neg[k-1];
        end
        for (int k = 5; k <= 21; k++) begin
            if (i_en[k]) r_x[k] <= r_x[k-1];
        end
        for (int k = 6; k <= 19; k++) begin
            if (i_en[k]) r_x2[k] <= r_x2[k-1];
        end
        if (i_en[22]) begin
            r_y <= yy[61:30];
        end
        if (i_en[23]) begin
            r_sin <= r_neg[22] ? 32'sd0 - $signed(32'(m_clamp)) : $signed(32'(m_clamp));
        end
    end

    for (genvar i = 0; i < ypb_pkg::HORNER_STEPS; i++) begin : g_h
        localparam int D = ypb_pkg::horner_div(i);
        localparam int L = $clog2(D);
        localparam int S = 32 + L;
        localparam logic [32:0] M = 33'(((64'd1 << S) + 64'(D) - 64'd1) / 64'(D));

        logic [30:0] p_in;
        logic [62:0] prod_a;
        logic [64:0] prod_q;

        if (i == 0) begin : g_first
            assign p_in = ypb_pkg::ONE_Q30;
        end else begin : g_next
            assign p_in = r_p[i-1];
        end

        assign prod_a = 63'(r_x2[5+2*i]) * 63'(p_in);
        assign prod_q = 65'(r_a[i]) * 65'(M);

        always_ff @(posedge i_clk) begin
            if (i_en[6+2*i]) r_a[i] <= prod_a[61:30];
            if (i_en[7+2*i]) r_p[i] <= ypb_pkg::ONE_Q30 - 31'(prod_q >> S);
        end
    end

    assign o_sin = r_sin;

endmodule

[src/yaw_pitch_to_basis_vectors.sv]
`timescale 1ns / 1ps
// Channel  Handshake             Beat
// in       i_valid / o_ready     i_yaw_deg, i_pitch_deg
// out      o_valid / i_ready     o_yaw_wrapped, o_front_*, o_right_*, o_up_*, o_degenerate
//
// One beat per cycle in and out while the receiver is ready; stages in order: wrap,
// 24-stage sine pipe, product stage, rounding stage. Four sine pipes run side by side.
// Each stage holds its own valid bit and advances when the next stage is empty
// or advancing, so a stall fills bubbles and loses nothing.
// Synchronous active-low reset clears the valid bits only.

module yaw_pitch_to_basis_vectors #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int VEC_FRAC_BITS   = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [16:0] i_yaw_deg,
    input  logic signed [13:0] i_pitch_deg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_yaw_wrapped,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic               o_degenerate
);

    localparam int A     = ANGLE_FRAC_BITS;
    localparam int EW    = (A + 12 > 19) ? A + 12 : 19;
    localparam int SL    = ypb_pkg::SINE_LAT;
    localparam int NST   = SL + 3;
    localparam int SH_S  = 30 - VEC_FRAC_BITS;
    localparam int SH_P  = 60 - VEC_FRAC_BITS;
    localparam logic [63:0] HALF_S = (64'd1 << SH_S) >> 1;
    localparam logic signed [EW-1:0] YAW_HI  = EW'(270 << A);
    localparam logic signed [EW-1:0] YAW_LO  = -EW'(90 << A);
    localparam logic signed [EW-1:0] FULL    = EW'(360 << A);
    localparam logic signed [EW-1:0] QUARTER = EW'(90 << A);

    function automatic logic [15:0] rnd16(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        mag = v[63] ? 64'd0 - 64'(v) : 64'(v);
        mag = (mag + ((64'd1 << sh) >> 1)) >> sh;
        return v[63] ? 16'd0 - mag[15:0] : mag[15:0];
    endfunction

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    logic signed [EW-1:0] n_yaw_a, n_yaw_b;
    logic signed [EW-1:0] r_ay, r_ayc, r_ap, r_apc;
    logic signed [16:0]   r_yw [0:NST-1];

    logic signed [31:0] sy, cy, sp, cp;
    logic signed [63:0] r_cycp, r_sycp, r_cysp, r_sysp;
    logic signed [31:0] r_sy, r_cy, r_sp, r_cp;

    logic [31:0] cp_mag;
    logic [32:0] cp_rnd;
    logic        degen;
    logic [15:0] rs_sy, rs_cy, rs_cp;

    logic signed [15:0] r_fx, r_fy, r_fz, r_rx, r_rz, r_ux, r_uy, r_uz;
    logic               r_dg;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n_yaw_a = EW'(i_yaw_deg);
        if (n_yaw_a > YAW_HI) begin
            n_yaw_a = n_yaw_a - FULL;
        end
        n_yaw_b = n_yaw_a;
        if (n_yaw_b < YAW_LO) begin
            n_yaw_b = n_yaw_b + FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ay    <= n_yaw_b;
            r_ayc   <= n_yaw_b + QUARTER;
            r_ap    <= EW'(i_pitch_deg);
            r_apc   <= EW'(i_pitch_deg) + QUARTER;
            r_yw[0] <= n_yaw_b[16:0];
        end
        for (int k = 1; k < NST; k++) begin
            if (en[k]) r_yw[k] <= r_yw[k-1];
        end
    end

    ypb_sine #(.ANGLE_FRAC_BITS(A), .EW(EW)) u_sy (
        .i_clk(i_clk), .i_en(en[SL:1]), .i_ang(r_ay),  .o_sin(sy)
    );
    ypb_sine #(.ANGLE_FRAC_BITS(A), .EW(EW)) u_cy (
        .i_clk(i_clk), .i_en(en[SL:1]), .i_ang(r_ayc), .o_sin(cy)
    );
    ypb_sine #(.ANGLE_FRAC_BITS(A), .EW(EW)) u_sp (
        .i_clk(i_clk), .i_en(en[SL:1]), .i_ang(r_ap),  .o_sin(sp)
    );
    ypb_sine #(.ANGLE_FRAC_BITS(A), .EW(EW)) u_cp (
        .i_clk(i_clk), .i_en(en[SL:1]), .i_ang(r_apc), .o_sin(cp)
    );

    always_ff @(posedge i_clk) begin
        if (en[SL+1]) begin
            r_cycp <= 64'(cy) * 64'(cp);
            r_sycp <= 64'(sy) * 64'(cp);
            r_cysp <= 64'(cy) * 64'(sp);
            r_sysp <= 64'(sy) * 64'(sp);
            r_sy   <= sy;
            r_cy   <= cy;
            r_sp   <= sp;
            r_cp   <= cp;
        end
    end

    assign cp_mag = r_cp[31] ? 32'd0 - 32'(r_cp) : 32'(r_cp);
    assign cp_rnd = (33'(cp_mag) + 33'(HALF_S)) >> SH_S;
    assign degen  = (cp_rnd == 33'd0);
    assign rs_sy  = rnd16(64'(r_sy), SH_S);
    assign rs_cy  = rnd16(64'(r_cy), SH_S);
    assign rs_cp  = rnd16(64'(r_cp), SH_S);

    always_ff @(posedge i_clk) begin
        if (en[SL+2]) begin
            r_fx <= rnd16(r_cycp, SH_P);
            r_fy <= rnd16(64'(r_sp), SH_S);
            r_fz <= rnd16(r_sycp, SH_P);
            r_dg <= degen;
            if (degen) begin
                r_rx <= '0;
                r_rz <= '0;
                r_ux <= '0;
                r_uy <= '0;
                r_uz <= '0;
            end else if (r_cp[31]) begin
                r_rx <= rs_sy;
                r_rz <= 16'd0 - rs_cy;
                r_ux <= rnd16(r_cysp, SH_P);
                r_uy <= 16'd0 - rs_cp;
                r_uz <= rnd16(r_sysp, SH_P);
            end else begin
                r_rx <= 16'd0 - rs_sy;
                r_rz <= rs_cy;
                r_ux <= 16'd0 - rnd16(r_cysp, SH_P);
                r_uy <= rs_cp;
                r_uz <= 16'd0 - rnd16(r_sysp, SH_P);
            end
        end
    end

    assign o_ready       = en[0];
    assign o_valid       = r_v[NST-1];
    assign o_yaw_wrapped = r_yw[NST-1];
    assign o_front_x     = r_fx;
    assign o_front_y     = r_fy;
    assign o_front_z     = r_fz;
    assign o_right_x     = r_rx;
    assign o_right_y     = '0;
    assign o_right_z     = r_rz;
    assign o_up_x        = r_ux;
    assign o_up_y        = r_uy;
    assign o_up_z        = r_uz;
    assign o_degenerate  = r_dg;

endmodule

[src/ypb_chk.sv]
`timescale 1ns / 1ps

module ypb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_right_x,
    input logic signed [15:0] o_right_y,
    input logic signed [15:0] o_right_z,
    input logic signed [15:0] o_up_x,
    input logic signed [15:0] o_up_y,
    input logic signed [15:0] o_up_z,
    input logic               o_degenerate
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid out after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("beat dropped while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_right_x == 16'sd0 && o_right_z == 16'sd0 &&
            o_up_x == 16'sd0 && o_up_y == 16'sd0 && o_up_z == 16'sd0)
        else $error("degenerate beat with non-zero right/up");

    a_right_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_right_y == 16'sd0)
        else $error("right y non-zero");

endmodule

bind yaw_pitch_to_basis_vectors ypb_chk u_ypb_chk (.*);

[tb/yaw_pitch_to_basis_vectors_chk.sv]
`timescale 1ns / 1ps

module yaw_pitch_to_basis_vectors_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [16:0] i_yaw_deg,
    input  logic signed [13:0] i_pitch_deg,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [16:0] o_yaw_wrapped,
    input  logic signed [15:0] o_front_x,
    input  logic signed [15:0] o_front_y,
    input  logic signed [15:0] o_front_z,
    input  logic signed [15:0] o_right_x,
    input  logic signed [15:0] o_right_y,
    input  logic signed [15:0] o_right_z,
    input  logic signed [15:0] o_up_x,
    input  logic signed [15:0] o_up_y,
    input  logic signed [15:0] o_up_z,
    input  logic               o_degenerate,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_beats_out,
    output int                 o_degen_seen
);

    localparam int AFB = 6;
    localparam int VFB = 14;
    localparam longint PI_Q = 64'd3373259426;
    localparam longint ONE_Q = 64'd1 << 30;
    localparam longint FULL_TURN = 360 << AFB;
    localparam longint QTR_TURN = 90 << AFB;

    typedef struct packed {
        logic signed [16:0] yaw;
        logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
        logic               degen;
    } t_basis;

    t_basis basis_q[$];

    function automatic longint quarter_sine(longint t);
        longint unsigned x, x2, p, d;
        x = (longint'(t) * PI_Q) / (180 << AFB);
        x2 = (x * x) >> 30;
        p = ONE_Q;
        for (int k = 8; k >= 1; k--) begin
            d = (2 * k) * (2 * k + 1);
            p = ONE_Q - ((x2 * p) >> 30) / d;
        end
        p = (x * p) >> 30;
        return (p > ONE_Q) ? ONE_Q : p;
    endfunction

    function automatic longint sine_q30(longint v);
        longint r, q, f, m;
        r = v % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        q = r / QTR_TURN;
        f = r - q * QTR_TURN;
        m = q[0] ? quarter_sine(QTR_TURN - f) : quarter_sine(f);
        return (q >= 2) ? -m : m;
    endfunction

    function automatic longint rnd_away(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] vec1(longint q);
        return 16'(rnd_away(q, 30 - VFB));
    endfunction

    function automatic logic [15:0] vec2(longint a, longint b);
        return 16'(rnd_away(a * b, 60 - VFB));
    endfunction

    function automatic t_basis camera_basis(logic signed [16:0] yi, logic signed [13:0] pi_);
        t_basis b;
        longint yaw, sy, cy, sp, cp, s;
        yaw = yi;
        if (yaw > (270 << AFB)) yaw -= FULL_TURN;
        if (yaw < -(90 << AFB)) yaw += FULL_TURN;
        sy = sine_q30(yaw);
        cy = sine_q30(yaw + QTR_TURN);
        sp = sine_q30(pi_);
        cp = sine_q30(longint'(pi_) + QTR_TURN);
        b = '0;
        b.yaw = 17'(yaw);
        b.fx = vec2(cy, cp);
        b.fy = vec1(sp);
        b.fz = vec2(sy, cp);
        if (rnd_away(cp, 30 - VFB) == 0) begin
            b.degen = 1'b1;
        end else begin
            s = (cp < 0) ? -1 : 1;
            b.rx = vec1(-s * sy);
            b.rz = vec1(s * cy);
            b.ux = vec2(-s * cy, sp);
            b.uy = vec1(s * cp);
            b.uz = vec2(-s * sy, sp);
        end
        return b;
    endfunction

    task automatic cmp(string nm, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, exp_v, act_v);
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_beats_out = 0;
        o_degen_seen = 0;
    end

    always @(posedge i_clk) begin
        t_basis e;
        if (i_rst_n) begin
            if (i_valid && o_ready) basis_q.push_back(camera_basis(i_yaw_deg, i_pitch_deg));
            if (o_valid && i_ready) begin
                o_beats_out++;
                if (basis_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected output beat", $time);
                end else begin
                    e = basis_q.pop_front();
                    if (e.degen) o_degen_seen++;
                    cmp("yaw_wrapped", e.yaw, o_yaw_wrapped);
                    cmp("front_x", e.fx, o_front_x);
                    cmp("front_y", e.fy, o_front_y);
                    cmp("front_z", e.fz, o_front_z);
                    cmp("right_x", e.rx, o_right_x);
                    cmp("right_y", e.ry, o_right_y);
                    cmp("right_z", e.rz, o_right_z);
                    cmp("up_x", e.ux, o_up_x);
                    cmp("up_y", e.uy, o_up_y);
                    cmp("up_z", e.uz, o_up_z);
                    cmp("degenerate", e.degen, o_degenerate);
                end
            end
        end
        o_pending = basis_q.size();
    end

endmodule

[tb/yaw_pitch_to_basis_vectors_tb.sv]
`timescale 1ns / 1ps

module yaw_pitch_to_basis_vectors_tb;

    localparam int N_RANDOM = 750;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [16:0] i_yaw_deg = '0;
    logic signed [13:0] i_pitch_deg = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [16:0] o_yaw_wrapped;
    logic signed [15:0] o_front_x, o_front_y, o_front_z;
    logic signed [15:0] o_right_x, o_right_y, o_right_z;
    logic signed [15:0] o_up_x, o_up_y, o_up_z;
    logic               o_degenerate;
    int                 errors, pending, beats_out, degen_seen;
    int                 cycles = 0;
    int                 sent = 0;
    bit                 long_hold = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    yaw_pitch_to_basis_vectors u_dut (.*);

    yaw_pitch_to_basis_vectors_chk u_chk (
        .*,
        .o_errors(errors),
        .o_pending(pending),
        .o_beats_out(beats_out),
        .o_degen_seen(degen_seen)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (150) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_beat(logic signed [16:0] y, logic signed [13:0] p, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_yaw_deg <= y;
        i_pitch_deg <= p;
        @(posedge i_clk iff o_ready);
        sent++;
    endtask

    function automatic logic signed [13:0] rand_pitch();
        case ($urandom_range(0, 5))
            0: return 14'($urandom_range(0, 8)) + 14'sd5752;
            1: return -14'sd5760 + 14'($urandom_range(0, 8));
            2: return 14'($urandom_range(0, 16383));
            default: return 14'(int'($urandom_range(0, 11520)) - 5760);
        endcase
    endfunction

    function automatic logic signed [16:0] rand_yaw();
        case ($urandom_range(0, 4))
            0: return 17'($urandom_range(0, 131071));
            1: return 17'(int'($urandom_range(0, 64)) + 17280 - 32);
            2: return 17'(int'($urandom_range(0, 64)) - 5760 - 32);
            default: return 17'(int'($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    initial begin
        logic signed [16:0] yaws[10] = '{0, 17280, 17281, -5760, -5761, 65535, -65536,
                                         23040, 5760, 11520};
        logic signed [13:0] pitches[9] = '{0, 5760, -5760, 5759, -5759, 8191, -8192,
                                           5761, 2880};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 10; k++) send_beat(yaws[k], pitches[k % 9], 0);
        for (int k = 0; k < 9; k++) send_beat(yaws[(k * 3) % 10], pitches[k], 1);
        for (int k = 0; k < 4; k++) send_beat(-17'sd1, 14'sd1 - 14'(k), 0);
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 200) long_hold = 1'b1;
            if (k == 400) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            send_beat(rand_yaw(), rand_pitch(),
                      ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5));
        end
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        $display("%0d beats sent, %0d results checked, %0d degenerate", sent, beats_out,
                 degen_seen);
        $display("covered yaw wrap edges, pitch at and beyond +-90 and full field range");
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[yaw_pitch_to_basis_vectors.f]
src/ypb_pkg.sv
src/ypb_sine.sv
src/yaw_pitch_to_basis_vectors.sv
src/ypb_chk.sv
tb/yaw_pitch_to_basis_vectors_chk.sv
tb/yaw_pitch_to_basis_vectors_tb.sv
